// ----- rtl/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

  // Queue depth and field widths.
  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STAT_W   = 2;

  // Operation codes carried in the input tuser.
  typedef enum logic [0:0] {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  // Result codes carried in the output tuser.
  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REMOVED  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
`default_nettype none

module spq_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire            out_tready,
  output spq_pkg::cmd_t  cmd
);

  spq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // The output register can take a new beat when empty or being drained.
  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::ST_IDLE: if (in_tvalid) state_nxt = spq_pkg::ST_EXEC;
      spq_pkg::ST_EXEC: if (out_free) state_nxt = spq_pkg::ST_IDLE;
      default:          state_nxt = spq_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_tready   = 1'b0;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      spq_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      spq_pkg::ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Output valid flag: set by an executed item, cleared when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/spq_datapath.sv -----
`default_nettype none

module spq_datapath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  spq_pkg::cmd_t                    cmd,
  input  wire                              in_action,
  input  wire  signed [spq_pkg::KEY_W-1:0] in_value,
  output logic signed [spq_pkg::KEY_W-1:0] removed_value,
  output logic [spq_pkg::STAT_W-1:0]       status,
  output logic [spq_pkg::CNT_W-1:0]        entry_count
);

  // Sorted cell row and occupancy.
  logic signed [spq_pkg::KEY_W-1:0] entries_r   [spq_pkg::CAPACITY];
  logic signed [spq_pkg::KEY_W-1:0] entries_nxt [spq_pkg::CAPACITY];
  logic [spq_pkg::CNT_W-1:0]        count_r, count_nxt;

  // Captured input beat.
  logic                             action_r;
  logic signed [spq_pkg::KEY_W-1:0] key_r;

  // Result register.
  logic signed [spq_pkg::KEY_W-1:0] removed_r, removed_nxt;
  logic [spq_pkg::STAT_W-1:0]       status_r, status_nxt;
  logic [spq_pkg::CNT_W-1:0]        rcount_r;

  logic [spq_pkg::CAPACITY-1:0]     le;
  logic [spq_pkg::CAPACITY-1:0]     prev_le;
  logic                             is_full;
  logic                             is_empty;

  assign is_full  = (count_r == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign is_empty = (count_r == '0);

  // Each occupied cell compares its key with the new one; the result is a prefix mask.
  always_comb begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      le[i] = (count_r > spq_pkg::CNT_W'(i)) && (entries_r[i] <= key_r);
    end
    prev_le = {le[spq_pkg::CAPACITY-2:0], 1'b1};
  end

  // Cell update: keep, take the new key, or shift from a neighbor.
  always_comb begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    count_nxt   = count_r;
    removed_nxt = '0;
    status_nxt  = spq_pkg::STAT_INSERTED;
    if (action_r == spq_pkg::ACT_INSERT) begin
      if (is_full) begin
        status_nxt = spq_pkg::STAT_FULL;
      end else begin
        status_nxt = spq_pkg::STAT_INSERTED;
        count_nxt  = count_r + 1'b1;
        // The front cell has no lower neighbor to shift from.
        if (!le[0]) begin
          entries_nxt[0] = key_r;
        end
        for (int i = 1; i < spq_pkg::CAPACITY; i++) begin
          if (le[i]) begin
            entries_nxt[i] = entries_r[i];
          end else if (prev_le[i]) begin
            entries_nxt[i] = key_r;
          end else begin
            entries_nxt[i] = entries_r[i-1];
          end
        end
      end
    end else begin
      if (is_empty) begin
        status_nxt = spq_pkg::STAT_EMPTY;
      end else begin
        status_nxt  = spq_pkg::STAT_REMOVED;
        removed_nxt = entries_r[0];
        count_nxt   = count_r - 1'b1;
        for (int i = 0; i < spq_pkg::CAPACITY - 1; i++) begin
          entries_nxt[i] = entries_r[i+1];
        end
      end
    end
  end

  // Occupancy is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r <= in_action;
      key_r    <= in_value;
    end
    if (cmd.exec) begin
      for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
      removed_r <= removed_nxt;
      status_r  <= status_nxt;
      rcount_r  <= count_nxt;
    end
  end

  assign removed_value = removed_r;
  assign status        = status_r;
  assign entry_count   = rcount_r;

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
// Channel  Direction  tdata                            tuser
// in_      slave      [31:0] value                     [0] action
// out_     master     [31:0] removed_value,            [1:0] status
//                     [36:32] entry_count, rest zero
//
// Each item is captured from the beat in the idle state; in the execute step the
// sorted cell row compares all stored keys against it and shifts in parallel.
// A new beat is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous) empties the queue; stored keys are not cleared.
// A stalled output holds the item in the execute step until the previous result is taken.
`default_nettype none

module sorted_priority_queue (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] value
  input  wire  [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] removed_value, [36:32] entry_count
  output logic [1:0]  out_tuser   // [1:0] status
);

  spq_pkg::cmd_t                    cmd;
  logic signed [spq_pkg::KEY_W-1:0] removed_value;
  logic [spq_pkg::STAT_W-1:0]       status;
  logic [spq_pkg::CNT_W-1:0]        entry_count;

  // Handshake controller.
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Sorted cell row and result register.
  spq_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_action     (in_tuser[0]),
    .in_value      ($signed(in_tdata)),
    .removed_value (removed_value),
    .status        (status),
    .entry_count   (entry_count)
  );

  assign out_tdata = {3'b000, entry_count, removed_value};
  assign out_tuser = status;

endmodule

`default_nettype wire
